// ----- rtl/irnec_pkg.sv -----
// Shared types and constants for the infrared pulse capture and NEC frame decoder.
// Holds command and status codes, register indexes, NEC timing windows and the result struct.
// No dependencies.
package irnec_pkg;

	// Width of one stored interval and of every timing register, in microseconds
	localparam int DATA_W    = 14;
	localparam int CFG_IDX_W = 2;

	// Request commands
	localparam logic CMD_EDGE   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// Decode status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_LEADER = 2'd1;
	localparam logic [1:0] STAT_REPEAT    = 2'd2;
	localparam logic [1:0] STAT_TOO_FEW   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 2'd2;

	// Register reset values
	localparam logic [DATA_W-1:0] MIN_PULSE_RST = 14'd200;
	localparam logic [DATA_W-1:0] MAX_PULSE_RST = 14'd15000;
	localparam logic [DATA_W-1:0] ONE_SPACE_RST = 14'd1125;

	// NEC timing windows (open intervals, microseconds)
	localparam logic [DATA_W-1:0] LEADER_MARK_LO  = 14'd8500;
	localparam logic [DATA_W-1:0] LEADER_MARK_HI  = 14'd9500;
	localparam logic [DATA_W-1:0] LEADER_SPACE_LO = 14'd4000;
	localparam logic [DATA_W-1:0] LEADER_SPACE_HI = 14'd5000;
	localparam logic [DATA_W-1:0] REPEAT_SPACE_LO = 14'd1800;
	localparam logic [DATA_W-1:0] REPEAT_SPACE_HI = 14'd2800;
	localparam logic [DATA_W-1:0] DATA_MARK_LO    = 14'd400;
	localparam logic [DATA_W-1:0] DATA_MARK_HI    = 14'd750;

	localparam int MIN_DATA_INTERVALS = 64;
	localparam int MAX_BITS           = 32;

	typedef struct packed {
		logic [DATA_W-1:0] min_us;
		logic [DATA_W-1:0] max_us;
	} pulse_cfg_t;

	typedef struct packed {
		logic [31:0] ir_code;
		logic [5:0]  bits_found;
		logic [1:0]  status;
	} result_t;

	function automatic logic in_open(logic [DATA_W-1:0] v, logic [DATA_W-1:0] lo,
			logic [DATA_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

endpackage

// ----- rtl/irnec_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module irnec_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/irnec_capture.sv -----
// Edge capture pipeline: timestamp difference, tick-to-microsecond scaling, window check
// and append into the interval store. Owns the previous timestamp and the fill count.
// Depends on irnec_pkg.
module irnec_capture #(
	parameter int STORE_DEPTH  = 256,
	parameter int TICKS_PER_US = 40,
	localparam int CW = $clog2(STORE_DEPTH + 1),
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             edge_go,
	input  logic [31:0]                      edge_time,
	input  irnec_pkg::pulse_cfg_t            cfg,
	input  logic                             clr,
	output logic [CW-1:0]                    count,
	output logic                             busy,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [irnec_pkg::DATA_W-1:0]     wr_data
);

	import irnec_pkg::*;

	// Any stored interval is below 16384 us, so its tick count fits NB bits.
	// Scale by a rounded-up reciprocal: exact floor division for all such counts.
	localparam int LB = $clog2(TICKS_PER_US);
	localparam int NB = DATA_W + LB;
	localparam int SH = NB + LB;
	localparam int MW = NB + 1;
	localparam int PW = NB + MW;
	localparam int TW = NB + 1;
	localparam longint unsigned RECIP =
		((longint'(1) << SH) + longint'(TICKS_PER_US) - longint'(1)) / longint'(TICKS_PER_US);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
	localparam logic [TW-1:0] TICKS   = TW'(TICKS_PER_US);

	logic [31:0]   prev_q;
	logic [CW-1:0] count_q;
	logic [TW-1:0] lo_ticks_q;
	logic [TW-1:0] hi_ticks_q;
	logic          v_s1;
	logic [31:0]   delta_s1;
	logic          v_s2;
	logic          keep_s2;
	logic [PW-1:0] prod_s2;

	// Control: valid flags, previous timestamp, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= edge_go;
			v_s2 <= v_s1;
			if (edge_go) begin
				prev_q <= edge_time;
			end
			if (clr) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Window bounds in ticks: us > min  <=>  ticks >= (min+1)*T ; us < max  <=>  ticks < max*T
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_ticks_q <= (TW'(MIN_PULSE_RST) + TW'(1)) * TICKS;
			hi_ticks_q <= TW'(MAX_PULSE_RST) * TICKS;
		end else begin
			lo_ticks_q <= (TW'(cfg.min_us) + TW'(1)) * TICKS;
			hi_ticks_q <= TW'(cfg.max_us) * TICKS;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_go) begin
			delta_s1 <= prev_q - edge_time;
		end
		keep_s2 <= (delta_s1 >= 32'(lo_ticks_q)) && (delta_s1 < 32'(hi_ticks_q));
		prod_s2 <= PW'(delta_s1[NB-1:0]) * PW'(RECIP_M);
	end

	assign wr_en   = v_s2 && keep_s2 && (count_q < CW'(STORE_DEPTH));
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = prod_s2[SH +: DATA_W];
	assign count   = count_q;
	assign busy    = v_s1 || v_s2;

endmodule

// ----- rtl/irnec_decode.sv -----
// Frame decode sequencer: walks the interval store one entry a cycle, finds the leader,
// then collects mark/space bits. Depends on irnec_pkg.
module irnec_decode #(
	parameter int STORE_DEPTH = 256,
	localparam int CW = $clog2(STORE_DEPTH + 1),
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [CW-1:0]                count,
	input  logic [irnec_pkg::DATA_W-1:0] one_space_us,
	input  logic                         out_free,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	input  logic [irnec_pkg::DATA_W-1:0] rd_data,
	output logic                         busy,
	output logic                         done,
	output irnec_pkg::result_t           result
);

	import irnec_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LEAD = 2'd1;
	localparam logic [1:0] ST_DATA = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     idx_q;
	logic              vld_s1;
	logic [CW-1:0]     pos_s1;
	logic [DATA_W-1:0] prev_q;
	logic              prev_ok_q;
	logic              have_mark_q;
	logic [31:0]       code_q;
	logic [5:0]        bits_q;
	logic [1:0]        status_q;

	logic          last;
	logic [CW-1:0] remaining;
	logic          too_few;
	logic          lead_mark;
	logic          lead_space;
	logic          rep_space;
	logic          data_mark;

	assign rd_en   = ((state_q == ST_LEAD) || (state_q == ST_DATA)) && (idx_q < count);
	assign rd_addr = idx_q[AW-1:0];

	assign last       = (pos_s1 == (count - CW'(1)));
	assign remaining  = count - pos_s1 - CW'(1);
	assign too_few    = remaining < CW'(MIN_DATA_INTERVALS);
	assign lead_mark  = in_open(prev_q, LEADER_MARK_LO, LEADER_MARK_HI);
	assign lead_space = in_open(rd_data, LEADER_SPACE_LO, LEADER_SPACE_HI);
	assign rep_space  = in_open(rd_data, REPEAT_SPACE_LO, REPEAT_SPACE_HI);
	assign data_mark  = in_open(rd_data, DATA_MARK_LO, DATA_MARK_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			pos_s1      <= '0;
			prev_q      <= '0;
			prev_ok_q   <= 1'b0;
			have_mark_q <= 1'b0;
			code_q      <= '0;
			bits_q      <= '0;
			status_q    <= STAT_NO_LEADER;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				pos_s1 <= idx_q;
				idx_q  <= idx_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q       <= '0;
						prev_ok_q   <= 1'b0;
						have_mark_q <= 1'b0;
						code_q      <= '0;
						bits_q      <= '0;
						if (count == '0) begin
							status_q <= STAT_NO_LEADER;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_LEAD;
						end
					end
				end
				ST_LEAD: begin
					if (vld_s1) begin
						prev_q    <= rd_data;
						prev_ok_q <= 1'b1;
						if (prev_ok_q && lead_mark && lead_space) begin
							// data opens at the entry after this space
							if (too_few) begin
								status_q <= STAT_TOO_FEW;
								state_q  <= ST_DONE;
							end else begin
								status_q <= STAT_OK;
								state_q  <= ST_DATA;
							end
						end else if (prev_ok_q && lead_mark && rep_space) begin
							status_q <= STAT_REPEAT;
							state_q  <= ST_DONE;
						end else if (last) begin
							status_q <= STAT_NO_LEADER;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_DATA: begin
					if (vld_s1) begin
						if (have_mark_q) begin
							code_q      <= {code_q[30:0], (rd_data > one_space_us)};
							bits_q      <= bits_q + 6'd1;
							have_mark_q <= 1'b0;
						end else if (data_mark && !last) begin
							have_mark_q <= 1'b1;
						end
						if (last || (have_mark_q && (bits_q == 6'(MAX_BITS - 1)))) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = (state_q == ST_DONE) && out_free;
	assign result.ir_code    = code_q;
	assign result.bits_found = bits_q;
	assign result.status     = status_q;

endmodule

// ----- rtl/ir_pulse_capture_nec_decoder.sv -----
// Top level of the infrared pulse capture and NEC frame decoder.
// Holds the timing registers and the result register; uses irnec_pkg, irnec_ram,
// irnec_capture and irnec_decode.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | into      | in_valid / in_stall  | command, edge_time
//   out     | out of    | out_valid / out_stall| ir_code, bits_found, decode_status
//   cfg     | into      | cfg_we (no wait)     | cfg_index, cfg_data
//
// Edges are taken one per cycle while no decode runs; each passes through the delta_s1
// and keep_s2/prod_s2 registers before it is written to the store. A decode waits for
// pending writes to drain, then reads one entry a cycle. Reset restores the timing
// registers and clears the fill count, previous timestamp and control state; the store
// itself is not swept. While a decode runs, in_stall holds every request; a result still
// waiting on out_stall holds the next decode at completion, and every request with it.
module ir_pulse_capture_nec_decoder #(
	parameter int STORE_DEPTH  = 256,
	parameter int TICKS_PER_US = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [31:0]                     edge_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     ir_code,
	output logic [5:0]                      bits_found,
	output logic [1:0]                      decode_status,
	input  logic                            cfg_we,
	input  logic [irnec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irnec_pkg::DATA_W-1:0]    cfg_data
);

	import irnec_pkg::*;

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);

	logic [DATA_W-1:0] min_pulse_q;
	logic [DATA_W-1:0] max_pulse_q;
	logic [DATA_W-1:0] one_space_q;

	logic        in_take;
	logic        edge_go;
	logic        dec_go;
	logic        cap_busy;
	logic        dec_busy;
	logic        dec_done;
	logic        out_free;
	pulse_cfg_t  pulse_cfg;
	result_t     dec_result;
	result_t     out_q;
	logic        out_valid_q;

	logic [CW-1:0]     count;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	// Timing registers; writes beyond the three indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RST;
			max_pulse_q <= MAX_PULSE_RST;
			one_space_q <= ONE_SPACE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_PULSE: min_pulse_q <= cfg_data;
				REG_MAX_PULSE: max_pulse_q <= cfg_data;
				REG_ONE_SPACE: one_space_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pulse_cfg.min_us = min_pulse_q;
	assign pulse_cfg.max_us = max_pulse_q;

	// Hold all requests while the store is being walked; hold a decode until pending
	// edge writes have landed, so reads and writes never touch the store together.
	assign in_stall = dec_busy || ((command == CMD_DECODE) && cap_busy);
	assign in_take  = in_valid && !in_stall;
	assign edge_go  = in_take && (command == CMD_EDGE);
	assign dec_go   = in_take && (command == CMD_DECODE);

	irnec_capture #(
		.STORE_DEPTH  (STORE_DEPTH),
		.TICKS_PER_US (TICKS_PER_US)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_go   (edge_go),
		.edge_time (edge_time),
		.cfg       (pulse_cfg),
		.clr       (dec_done),
		.count     (count),
		.busy      (cap_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	irnec_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	irnec_decode #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (dec_go),
		.count        (count),
		.one_space_us (one_space_q),
		.out_free     (out_free),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.busy         (dec_busy),
		.done         (dec_done),
		.result       (dec_result)
	);

	// Result register: load on decode completion, drop once the result is taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_done) begin
			out_q <= dec_result;
		end
	end

	assign out_valid     = out_valid_q;
	assign ir_code       = out_q.ir_code;
	assign bits_found    = out_q.bits_found;
	assign decode_status = out_q.status;

endmodule

// ----- tb/ir_pulse_capture_nec_decoder_test.sv -----
// Self-checking bench for ir_pulse_capture_nec_decoder: edge and decode requests in, NEC frames out.
// Predicts every decode result from its own interval store and compares field by field.
// Depends on irnec_pkg and the ir_pulse_capture_nec_decoder RTL.
module ir_pulse_capture_nec_decoder_test;

	import irnec_pkg::*;

	localparam int STORE_DEPTH  = 256;
	localparam int TICKS_PER_US = 40;
	localparam int ITEMS        = 1850;
	localparam int HOLD_CYCLES  = 400;
	// edge capture writes the store through its pipeline registers; leave ample margin
	localparam int SETTLE_CYCLES = 16;
	localparam int LIMIT_TIME    = 10_000_000;

	// no register sits at this index; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [DATA_W-1:0] MIN_US_DEFAULT = 14'd200;
	localparam logic [DATA_W-1:0] MAX_US_DEFAULT = 14'd15000;
	localparam logic [DATA_W-1:0] ONE_US_DEFAULT = 14'd1125;

	// NEC timing windows, open at both ends, in microseconds
	localparam int NEC_LDR_MARK_LO   = 8500;
	localparam int NEC_LDR_MARK_HI   = 9500;
	localparam int NEC_LDR_SPACE_LO  = 4000;
	localparam int NEC_LDR_SPACE_HI  = 5000;
	localparam int NEC_RPT_SPACE_LO  = 1800;
	localparam int NEC_RPT_SPACE_HI  = 2800;
	localparam int NEC_DATA_MARK_LO  = 400;
	localparam int NEC_DATA_MARK_HI  = 750;
	localparam int NEC_MIN_INTERVALS = 64;
	localparam int NEC_BITS          = 32;

	typedef struct {
		logic        cmd;
		logic [31:0] stamp;
	} request_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 command   = CMD_EDGE;
	logic [31:0]          edge_time = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [31:0]          ir_code;
	logic [5:0]           bits_found;
	logic [1:0]           decode_status;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	// request source and pacing
	request_t    pending[$];
	request_t    next_req;
	logic [31:0] gen_stamp;
	int          queued        = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_asked    = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;

	// predicted decoder state
	logic [DATA_W-1:0] min_lim, max_lim, one_lim;
	logic [31:0]       prev_stamp;
	logic [DATA_W-1:0] held_us[STORE_DEPTH];
	int                held;
	result_t           frames_due[$];
	result_t           want;

	// tallies
	int fails     = 0;
	int accepted  = 0;
	int decodes   = 0;
	int peak_held = 0;
	int status_hits[4] = '{0, 0, 0, 0};

	ir_pulse_capture_nec_decoder #(
		.STORE_DEPTH (STORE_DEPTH),
		.TICKS_PER_US(TICKS_PER_US)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.edge_time    (edge_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ir_code      (ir_code),
		.bits_found   (bits_found),
		.decode_status(decode_status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit open_win(int v, int lo, int hi);
		return (v > lo) && (v < hi);
	endfunction

	// Advance the predicted state by one accepted request; a decode queues its frame.
	function automatic void absorb_request(logic cmd, logic [31:0] stamp);
		logic [31:0] us;
		logic [31:0] code;
		logic [1:0]  st;
		logic        searching;
		int          i;
		int          start;
		int          nbits;
		result_t     res;
		accepted++;
		if (cmd == CMD_EDGE) begin
			// down-counting timer: elapsed ticks wrap modulo 2^32
			us = (prev_stamp - stamp) / TICKS_PER_US;
			prev_stamp = stamp;
			if (us > min_lim && us < max_lim && held < STORE_DEPTH) begin
				held_us[held] = us[DATA_W-1:0];
				held++;
				if (held > peak_held)
					peak_held = held;
			end
		end else begin
			decodes++;
			st = STAT_NO_LEADER;
			start = 0;
			code = '0;
			nbits = 0;
			searching = 1'b1;
			// first leader mark followed by a leader space wins; a repeat space after it ends the search too
			for (i = 0; searching && i + 1 < held; i++) begin
				if (open_win(held_us[i], NEC_LDR_MARK_LO, NEC_LDR_MARK_HI)) begin
					if (open_win(held_us[i+1], NEC_LDR_SPACE_LO, NEC_LDR_SPACE_HI)) begin
						st = STAT_OK;
						start = i + 2;
						searching = 1'b0;
					end else if (open_win(held_us[i+1], NEC_RPT_SPACE_LO, NEC_RPT_SPACE_HI)) begin
						st = STAT_REPEAT;
						searching = 1'b0;
					end
				end
			end
			if (st == STAT_OK && held - start < NEC_MIN_INTERVALS)
				st = STAT_TOO_FEW;
			if (st == STAT_OK) begin
				// a data mark consumes its space as the bit; anything else is skipped alone
				i = start;
				while (i + 1 < held && nbits < NEC_BITS) begin
					if (open_win(held_us[i], NEC_DATA_MARK_LO, NEC_DATA_MARK_HI)) begin
						code = {code[30:0], held_us[i+1] > one_lim};
						nbits++;
						i += 2;
					end else begin
						i++;
					end
				end
			end
			res.ir_code = code;
			res.bits_found = nbits[5:0];
			res.status = st;
			frames_due.push_back(res);
			held = 0;
		end
	endfunction

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %h, got %h", name, want_v, got_v);
			fails++;
		end
	endtask

	// Queue one request; edges also move the generator's running timestamp.
	task automatic offer(logic cmd, logic [31:0] stamp);
		request_t r;
		r.cmd = cmd;
		r.stamp = stamp;
		if (cmd == CMD_EDGE)
			gen_stamp = stamp;
		pending.push_back(r);
		queued++;
	endtask

	// Queue an edge that lands the given interval, with random sub-microsecond ticks.
	task automatic send_edge(int us);
		offer(CMD_EDGE, gen_stamp - 32'(us * TICKS_PER_US + $urandom_range(TICKS_PER_US - 1)));
	endtask

	// Mostly inside the open window, now and then on or just inside its ends.
	function automatic int window_pick(int lo, int hi);
		case ($urandom_range(19))
			0:       return lo;
			1:       return lo + 1;
			2:       return hi - 1;
			3:       return hi;
			default: return $urandom_range(lo + 1, hi - 1);
		endcase
	endfunction

	// One burst on the line: a full frame, a repeat code, a truncated frame or plain noise,
	// usually followed by a decode.
	task automatic queue_frame();
		int kind;
		int pairs;
		int k;
		kind = $urandom_range(99);
		// quiet gap ahead of the burst, too long to be stored
		send_edge($urandom_range(16400, 60000));
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4)) send_edge($urandom_range(0, 20000));
		if (kind < 82) begin
			send_edge(window_pick(NEC_LDR_MARK_LO, NEC_LDR_MARK_HI));
			if (kind < 70) begin
				send_edge(window_pick(NEC_LDR_SPACE_LO, NEC_LDR_SPACE_HI));
				if (kind < 58)
					pairs = ($urandom_range(5) == 0) ? $urandom_range(33, 40) : NEC_BITS;
				else
					pairs = $urandom_range(0, 31);
				for (k = 0; k < pairs; k++) begin
					send_edge(window_pick(NEC_DATA_MARK_LO, NEC_DATA_MARK_HI));
					case ($urandom_range(15))
						0:                   send_edge(int'(one_lim) + $urandom_range(1));
						1, 2, 3, 4, 5, 6, 7: send_edge($urandom_range(1500, 1800));
						default:             send_edge($urandom_range(400, 700));
					endcase
					// stray glitch shifts the mark/space pairing
					if ($urandom_range(19) == 0)
						send_edge($urandom_range(100, 3000));
				end
				// closing mark is dropped now and then, leaving exactly 64 after the leader for a plain 32-pair frame
				if ($urandom_range(3) != 0)
					send_edge(window_pick(NEC_DATA_MARK_LO, NEC_DATA_MARK_HI));
			end else begin
				send_edge(window_pick(NEC_RPT_SPACE_LO, NEC_RPT_SPACE_HI));
				send_edge(window_pick(NEC_DATA_MARK_LO, NEC_DATA_MARK_HI));
			end
		end else begin
			repeat ($urandom_range(1, 24)) begin
				if ($urandom_range(1))
					send_edge($urandom_range(0, 20000));
				else
					offer(CMD_EDGE, $urandom);
			end
		end
		// leave some bursts to pile up behind the next one
		if ($urandom_range(9) != 0)
			offer(CMD_DECODE, $urandom);
	endtask

	task automatic run_random(int quota);
		int stop_at;
		stop_at = queued + quota;
		while (queued < stop_at)
			queue_frame();
	endtask

	// Hold the source back until every queued request is taken and every frame is back.
	task automatic wait_results();
		while (pending.size() != 0 || in_valid || frames_due.size() != 0)
			@(negedge clk);
	endtask

	// Drain, then give in-flight edges time to reach the store.
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_pace(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// Write one register while the block is idle and mirror it in the prediction.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MIN_PULSE: min_lim = val;
			REG_MAX_PULSE: max_lim = val;
			REG_ONE_SPACE: one_lim = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: offer the next pending request whenever the slot is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_EDGE;
			edge_time <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending.pop_front();
				in_valid <= 1'b1;
				command <= next_req.cmd;
				edge_time <= next_req.stamp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result stall: a requested long hold takes precedence over random stalling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: check delivered frames against the oldest prediction, then absorb
	// whatever request was accepted at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("unexpected frame: ir_code %h bits_found %0d decode_status %0d",
						ir_code, bits_found, decode_status);
					fails++;
				end else begin
					want = frames_due.pop_front();
					check_field("ir_code", want.ir_code, ir_code);
					check_field("bits_found", want.bits_found, bits_found);
					check_field("decode_status", want.status, decode_status);
					status_hits[want.status]++;
				end
			end
			if (in_valid && !in_stall)
				absorb_request(command, edge_time);
		end
	end

	initial begin
		min_lim = MIN_US_DEFAULT;
		max_lim = MAX_US_DEFAULT;
		one_lim = ONE_US_DEFAULT;
		prev_stamp = '0;
		held = 0;
		gen_stamp = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// a write to the unused index must leave every threshold alone
		write_reg(REG_UNUSED, DATA_W'($urandom));
		set_pace(0, 0);

		// Directed: decode on an empty store gives no leader
		offer(CMD_DECODE, 32'hFFFF_FFFF);
		// timestamp extremes: one tick after reset, then a near-full wrap
		offer(CMD_EDGE, 32'hFFFF_FFFF);
		offer(CMD_EDGE, 32'h0000_0000);
		// store thresholds at their edges, counting down through zero
		send_edge(200);
		send_edge(201);
		send_edge(14999);
		send_edge(15000);
		// leader mark whose space fits neither window
		send_edge(9000);
		send_edge(3000);
		offer(CMD_DECODE, 32'h0000_0000);
		// repeat code
		send_edge(30000);
		send_edge(9000);
		send_edge(2250);
		offer(CMD_DECODE, $urandom);
		// leader with too few intervals behind it
		send_edge(9000);
		send_edge(4500);
		send_edge(560);
		send_edge(1690);
		offer(CMD_DECODE, $urandom);

		// Defaults, no idling on either side
		run_random(250);
		settle();

		// Widest store window, every data space a one; sender idles often
		write_reg(REG_MIN_PULSE, 14'd0);
		write_reg(REG_MAX_PULSE, 14'd16383);
		write_reg(REG_ONE_SPACE, 14'd0);
		set_pace(63, 0);
		run_random(250);
		settle();

		// Empty window: nothing is ever stored
		write_reg(REG_MIN_PULSE, 14'd16383);
		write_reg(REG_MAX_PULSE, 14'd0);
		write_reg(REG_ONE_SPACE, 14'd16383);
		set_pace(0, 0);
		run_random(40);
		settle();

		// Receiver stalls often; overfill the store behind a leader first
		write_reg(REG_MIN_PULSE, 14'd100);
		write_reg(REG_MAX_PULSE, 14'd12000);
		write_reg(REG_ONE_SPACE, DATA_W'($urandom_range(800, 1400)));
		set_pace(0, 63);
		send_edge(30000);
		send_edge(9000);
		send_edge(4500);
		repeat (150) begin
			send_edge(560);
			send_edge($urandom_range(1) ? 1690 : 560);
		end
		offer(CMD_DECODE, $urandom);
		run_random(150);
		settle();

		// Both sides idle; thresholds scattered around their nominal values
		write_reg(REG_MIN_PULSE, DATA_W'($urandom_range(0, 399)));
		write_reg(REG_MAX_PULSE, DATA_W'($urandom_range(9600, 16383)));
		write_reg(REG_ONE_SPACE, DATA_W'($urandom_range(700, 1600)));
		set_pace(28, 28);
		run_random(300);
		settle();

		// Hold results back for a long stretch while requests keep coming, so a second
		// decode backs up and the block stalls its input
		write_reg(REG_MIN_PULSE, MIN_US_DEFAULT);
		write_reg(REG_MAX_PULSE, MAX_US_DEFAULT);
		write_reg(REG_ONE_SPACE, ONE_US_DEFAULT);
		set_pace(0, 0);
		hold_asked++;
		offer(CMD_DECODE, $urandom);
		repeat (3) queue_frame();
		offer(CMD_DECODE, $urandom);
		settle();

		// Pause the sender after each burst until its frame is back
		set_pace(28, 0);
		repeat (4) begin
			queue_frame();
			wait_results();
		end

		// Finish at defaults with both sides idling
		set_pace(28, 28);
		while (queued < ITEMS)
			queue_frame();
		offer(CMD_DECODE, $urandom);
		settle();

		$display("covered %0d requests (%0d decodes), store filled to %0d of %0d intervals",
			accepted, decodes, peak_held, STORE_DEPTH);
		$display("frames checked: %0d ok, %0d no leader, %0d repeat, %0d too few",
			status_hits[STAT_OK], status_hits[STAT_NO_LEADER], status_hits[STAT_REPEAT],
			status_hits[STAT_TOO_FEW]);
		if (fails == 0)
			$display("ir_pulse_capture_nec_decoder_test: PASS");
		else
			$display("ir_pulse_capture_nec_decoder_test: FAIL");
		$finish;
	end

	// Guard against a hang: any missing frame or stuck handshake ends here
	initial begin
		#LIMIT_TIME;
		$display("ir_pulse_capture_nec_decoder_test: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/irnec_pkg.sv
rtl/irnec_ram.sv
rtl/irnec_capture.sv
rtl/irnec_decode.sv
rtl/ir_pulse_capture_nec_decoder.sv
tb/ir_pulse_capture_nec_decoder_test.sv
